// ===== hw/rtl/block_standard_deviation_unit_defines.svh =====
// Assertion macros shared by the block standard deviation RTL.
`ifndef BLOCK_STANDARD_DEVIATION_UNIT_DEFINES_SVH
`define BLOCK_STANDARD_DEVIATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSD_ASSERT_NOW(label, clk, rst, pre, con) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
      else $error("assertion failed: %m");
// next-cycle implication
`define BSD_ASSERT_NEXT(label, clk, rst, pre, con) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
      else $error("assertion failed: %m");
`else
`define BSD_ASSERT_NOW(label, clk, rst, pre, con)
`define BSD_ASSERT_NEXT(label, clk, rst, pre, con)
`endif
`endif

// ===== hw/rtl/bsd_pkg.sv =====
// Shared widths and constants of the block standard deviation unit.
package bsd_pkg;
   localparam int SAMPLE_W  = 16;
   localparam int STD_DEV_W = 16;
   localparam logic [STD_DEV_W-1:0] STD_DEV_MAX = '1;
   // upper bound on the result with Q15 samples
   localparam int STD_DEV_PEAK = 46341;
   // blocks that may wait between accumulator and arithmetic sequencer
   localparam int BSD_QUEUE_DEPTH = 2;
endpackage

// ===== hw/rtl/bsd_front.sv =====
// Front end: accumulates sum, sum of squares and count, hands closed blocks on.
module bsd_front #(
   parameter int MAX_BLOCK = 4096,
   localparam int CNT_W = $clog2(MAX_BLOCK + 1),
   localparam int SUM_W = bsd_pkg::SAMPLE_W + CNT_W,
   localparam int SQ_W  = 2 * bsd_pkg::SAMPLE_W - 2 + CNT_W,
   localparam int PAY_W = SUM_W + SQ_W + CNT_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bsd_pkg::SAMPLE_W-1:0]  req_tdata,
   input  logic                          req_tlast,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [PAY_W-1:0]              push_data
);
   import bsd_pkg::*;

   logic signed [SUM_W-1:0]      sum_ff, sum_in, sum_next;
   logic [SQ_W-1:0]              sq_ff, sq_in, sq_next;
   logic [CNT_W-1:0]             cnt_ff, cnt_in, cnt_next;
   logic                         ovf_ff, ovf_in, ovf_next;
   logic signed [SAMPLE_W-1:0]   sample;
   logic signed [2*SAMPLE_W-1:0] square;
   logic                         room;
   logic                         take;

   assign sample     = req_tdata;
   assign square     = sample * sample;
   assign room       = cnt_ff < CNT_W'(MAX_BLOCK);
   assign req_tready = push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = req_tvalid && req_tlast;
   assign push_data  = {ovf_next, cnt_next, sq_next, sum_next};

   always_comb begin
      // a full block drops the sample and only flags it
      sum_next = room ? sum_ff + SUM_W'(sample) : sum_ff;
      sq_next  = room ? sq_ff + SQ_W'(square[2*SAMPLE_W-2:0]) : sq_ff;
      cnt_next = room ? cnt_ff + 1'b1 : cnt_ff;
      ovf_next = ovf_ff | ~room;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      if (take) begin
         if (req_tlast) begin
            sum_in = '0;
            sq_in  = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sum_next;
            sq_in  = sq_next;
            cnt_in = cnt_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sq_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end
endmodule

// ===== hw/rtl/bsd_queue.sv =====
// Short register queue of closed blocks between front and back end.
`include "block_standard_deviation_unit_defines.svh"
module bsd_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;

   assign push_ready = fill_ff != FILL_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BSD_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(DEPTH))
   `BSD_ASSERT_NEXT(a_fill_up, clock, reset, push && !pop, fill_ff == $past(fill_ff) + 1'b1)
   `BSD_ASSERT_NEXT(a_fill_down, clock, reset, pop && !push, fill_ff == $past(fill_ff) - 1'b1)
endmodule

// ===== hw/rtl/bsd_back.sv =====
// Back end: sequencer for N*Q - S*S, the divide by N*(N-1) and the square root.
`include "block_standard_deviation_unit_defines.svh"
module bsd_back #(
   parameter int MAX_BLOCK = 4096,
   localparam int CNT_W = $clog2(MAX_BLOCK + 1),
   localparam int SUM_W = bsd_pkg::SAMPLE_W + CNT_W,
   localparam int SQ_W  = 2 * bsd_pkg::SAMPLE_W - 2 + CNT_W,
   localparam int PAY_W = SUM_W + SQ_W + CNT_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  logic [PAY_W-1:0]               q_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bsd_pkg::STD_DEV_W-1:0]  rsp_tdata,
   output logic                           rsp_tuser
);
   import bsd_pkg::*;

   localparam int MAG_W  = SUM_W - 1;
   localparam int NUM_W  = SQ_W + CNT_W;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int RT_W   = NUM_W + (NUM_W % 2);
   localparam int STEP_W = $clog2(NUM_W);
   localparam logic [RT_W-1:0] BIT_INIT = {2'b01, {(RT_W-2){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUB, ST_DIV, ST_ROOT, ST_OUT
   } state_type;

   state_type               state_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [CNT_W-1:0]        nbits_ff;
   logic [NUM_W-1:0]        mcand_ff;
   logic [NUM_W-1:0]        acc_ff;
   logic [NUM_W-1:0]        sq_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [RT_W-1:0]         v_ff;
   logic [RT_W-1:0]         res_ff;
   logic [RT_W-1:0]         bit_ff;
   logic                    small_ff;
   logic                    ovf_ff;
   logic                    rsp_valid_ff;
   logic [STD_DEV_W-1:0]    std_dev_ff;
   logic                    rsp_ovf_ff;

   logic signed [SUM_W-1:0] q_sum;
   logic [SQ_W-1:0]         q_sq;
   logic [CNT_W-1:0]        q_cnt;
   logic                    q_ovf;
   logic signed [SUM_W-1:0] q_abs;
   logic [DEN_W:0]          div_trial;
   logic [DEN_W:0]          div_sub;
   logic                    div_fit;
   logic [NUM_W-1:0]        div_quo;
   logic [RT_W-1:0]         root_sum;
   logic                    root_fit;
   logic                    out_free;
   logic [STD_DEV_W-1:0]    clamped;

   assign {q_ovf, q_cnt, q_sq, q_sum} = q_data;
   assign q_abs     = q_sum[SUM_W-1] ? -q_sum : q_sum;
   assign q_ready   = state_ff == ST_IDLE;
   assign div_trial = {rem_ff, num_ff[NUM_W-1]};
   assign div_sub   = div_trial - {1'b0, den_ff};
   assign div_fit   = div_trial >= {1'b0, den_ff};
   assign div_quo   = {num_ff[NUM_W-2:0], div_fit};
   assign root_sum  = res_ff + bit_ff;
   assign root_fit  = v_ff >= root_sum;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign clamped   = (res_ff > RT_W'(STD_DEV_MAX)) ? STD_DEV_MAX : res_ff[STD_DEV_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = std_dev_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT the register is either held or reloaded below
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  mag_ff   <= q_abs[MAG_W-1:0];
                  n_ff     <= q_cnt;
                  nbits_ff <= q_cnt;
                  mcand_ff <= NUM_W'(q_sq);
                  acc_ff   <= '0;
                  small_ff <= q_cnt < CNT_W'(2);
                  ovf_ff   <= q_ovf;
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // shift-add N*Q, one bit of N a cycle
               if (nbits_ff[0]) begin
                  acc_ff <= acc_ff + mcand_ff;
               end
               mcand_ff <= mcand_ff << 1;
               nbits_ff <= nbits_ff >> 1;
               sq_ff    <= mag_ff * mag_ff;
               den_ff   <= DEN_W'(n_ff) * (DEN_W'(n_ff) - DEN_W'(1));
               if (step_ff == STEP_W'(CNT_W - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_SUB;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SUB: begin
               num_ff   <= (acc_ff > sq_ff) ? acc_ff - sq_ff : '0;
               rem_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // restoring divide, one quotient bit a cycle
               num_ff <= div_quo;
               rem_ff <= div_fit ? div_sub[DEN_W-1:0] : div_trial[DEN_W-1:0];
               if (step_ff == STEP_W'(NUM_W - 1)) begin
                  v_ff     <= RT_W'(div_quo);
                  res_ff   <= '0;
                  bit_ff   <= BIT_INIT;
                  step_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               // digit-by-digit integer square root
               if (root_fit) begin
                  v_ff   <= v_ff - root_sum;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (step_ff == STEP_W'(RT_W / 2 - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  std_dev_ff   <= small_ff ? '0 : clamped;
                  rsp_ovf_ff   <= ovf_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `BSD_ASSERT_NOW(a_peak, clock, reset, rsp_valid_ff, std_dev_ff <= STD_DEV_W'(STD_DEV_PEAK))
   `BSD_ASSERT_NOW(a_rem_below_den, clock, reset, state_ff == ST_DIV && !small_ff, rem_ff < den_ff)
   `BSD_ASSERT_NOW(a_out_from_seq, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_OUT))
endmodule

// ===== hw/rtl/block_standard_deviation_unit.sv =====
// Top level of the block sample standard deviation unit.
// Computes the sample standard deviation sqrt((N*Q - S*S) / (N*(N-1))) of each
// block of signed Q15 samples, where S is the sum, Q the sum of squares and N the
// count; the result is unsigned Q15, truncated. One sample beat is taken per
// cycle while req_tready is high; req_tlast closes the block and produces exactly
// one result beat, whose tuser bit is set when samples beyond MAX_BLOCK were
// dropped. A block of one sample gives 0. The front end accumulates at full rate;
// a closed block then waits in a two-entry queue for the back-end sequencer,
// which runs the shift-add N*Q over the CNT_W = clog2(MAX_BLOCK+1) bits of N,
// the bit-serial divide of the NUM_W = 30 + 2*CNT_W bit numerator and the
// square root on NUM_W rounded up to even, and takes the next block only once
// it is back in idle; req_tready falls while the queue is full. The result sits
// in an output register, so the sequencer carries on with the next block while
// a result beat is held off by rsp_tready.
module block_standard_deviation_unit #(
   parameter int MAX_BLOCK = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bsd_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bsd_pkg::STD_DEV_W-1:0] rsp_tdata,   // [15:0] std_dev
   output logic                          rsp_tuser    // [0] block_overflow
);
   import bsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;
   localparam int SQ_W  = 2 * SAMPLE_W - 2 + CNT_W;
   // closed block: {overflow, count, sum of squares, sum}
   localparam int PAY_W = SUM_W + SQ_W + CNT_W + 1;

   logic             push_valid;
   logic             push_ready;
   logic [PAY_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [PAY_W-1:0] pop_data;

   // accumulator, one sample beat a cycle while the queue has room
   bsd_front #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples accumulation from the long arithmetic sequence
   bsd_queue #(
      .WIDTH (PAY_W),
      .DEPTH (BSD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // multiply, divide and square root, then the output register
   bsd_back #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_data     (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
